### hdl/motor_feedback_tracker_defines.svh
// Assertion macros for the motor feedback tracker checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef MOTOR_FEEDBACK_TRACKER_DEFINES_SVH
`define MOTOR_FEEDBACK_TRACKER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define MFT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define MFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that is also checked during reset.
`define MFT_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/mft_pkg.sv
// Shared types and constants of the motor feedback tracker.
// No dependencies; used by every other file of the block except the defines header.
package mft_pkg;

  localparam int FRAC_W  = 16;   // Q16.16 fraction bits
  localparam int SPEED_W = 32;   // filtered speed width
  localparam int ACC_W   = 52;   // filter accumulator, Q32 products
  localparam int MULT_W  = 17;   // multiplier bits walked by the serial MAC
  localparam int POS_W   = 21;   // position output width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Filter coefficients, Q16, as magnitude plus sign.
  localparam logic [MULT_W-1:0] COEF_NEWER_MAG = 17'd113096;
  localparam logic [MULT_W-1:0] COEF_OLDER_MAG = 17'd49542;
  localparam logic [MULT_W-1:0] COEF_INPUT_MAG = 17'd1982;

  // Round half up: seed the accumulator with half an output LSB.
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_SCALE       = 3'd0,
    REG_HALF_REVOLUTION   = 3'd1,
    REG_FULL_TURN_COUNT   = 3'd2,
    REG_PRESS_HOLD_LIMIT  = 3'd3,
    REG_SWITCH_HOLD_LIMIT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic               [15:0] motor_rpm;
    logic               [12:0] encoder_now;
    logic               [12:0] encoder_before;
    logic                      button_left;
    logic                      button_right;
    logic                      switch_down;
    logic                      shooter_active;
  } item_t;

  typedef struct packed {
    logic        [SPEED_W-1:0] filtered_speed;
    logic                [7:0] turn_count;
    logic          [POS_W-1:0] position_counts;
    logic               [15:0] left_hold_time;
    logic               [15:0] right_hold_time;
    logic               [15:0] switch_hold_time;
    logic                      left_previous;
    logic                      right_previous;
  } result_t;

  typedef struct packed {
    logic [15:0] speed_scale;
    logic [12:0] half_revolution;
    logic  [6:0] full_turn_count;
    logic [15:0] press_hold_limit;
    logic [15:0] switch_hold_limit;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic negate;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

  typedef struct packed {
    logic       [7:0] turn_count;
    logic [POS_W-1:0] position_counts;
  } turn_stat_t;

  typedef struct packed {
    logic [15:0] left_hold_time;
    logic [15:0] right_hold_time;
    logic [15:0] switch_hold_time;
    logic        left_previous;
    logic        right_previous;
  } hold_stat_t;

endpackage

### hdl/mft_if.sv
// Handshake channels of the motor feedback tracker: samples, results, config.
// Depends on mft_pkg.
interface mft_item_if;
  logic           valid;
  logic           ready;
  mft_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mft_result_if;
  logic             valid;
  logic             ready;
  mft_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mft_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mft_pkg::CFG_IDX_W-1:0]    index;
  logic [mft_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/mft_serial_mac.sv
// Bit-serial multiply-accumulate: one multiplier bit per cycle, shift-add.
// Depends on mft_pkg.
module mft_serial_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mft_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [mft_pkg::SPEED_W-1:0] operand_i,
  input  logic        [mft_pkg::MULT_W-1:0]  mult_i,
  input  logic signed [mft_pkg::ACC_W-1:0]   init_i,
  output mft_pkg::mac_stat_t                stat_o,
  output logic signed [mft_pkg::ACC_W-1:0]   acc_o
);

  localparam int CNT_W = $clog2(mft_pkg::MULT_W);

  logic                             busy_q;
  logic                             done_q;
  logic [CNT_W-1:0]                 cnt_q;
  logic signed [mft_pkg::ACC_W-1:0] acc_q;
  logic signed [mft_pkg::ACC_W-1:0] mcand_q;
  logic [mft_pkg::MULT_W-1:0]       mult_q;
  logic                             neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(mft_pkg::MULT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // datapath: multiplicand shifts up, multiplier shifts down
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mcand_q <= mft_pkg::ACC_W'(operand_i);
      mult_q  <= mult_i;
      neg_q   <= ctrl_i.negate;
      if (ctrl_i.clear) begin
        acc_q <= init_i;
      end
    end else if (busy_q) begin
      if (mult_q[0]) begin
        acc_q <= neg_q ? (acc_q - mcand_q) : (acc_q + mcand_q);
      end
      mcand_q <= mcand_q <<< 1;
      mult_q  <= mult_q >> 1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign acc_o       = acc_q;

endmodule

### hdl/mft_turn_track.sv
// Multi-turn encoder tracking: wrap detection, signed turn counter, position.
// Depends on mft_pkg. Runs a short fixed pipeline per sample.
module mft_turn_track #(
  parameter int REVOLUTION_COUNTS = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [12:0]         encoder_now_i,
  input  logic [12:0]         encoder_before_i,
  input  mft_pkg::cfg_t       cfg_i,
  output mft_pkg::turn_stat_t stat_o
);

  localparam int RC_W   = $clog2(REVOLUTION_COUNTS + 1);
  localparam int PROD_W = (8 + RC_W + 2 > mft_pkg::POS_W) ? (8 + RC_W + 2)
                                                          : mft_pkg::POS_W;
  localparam logic signed [PROD_W-1:0] REV_COUNTS_S = PROD_W'(REVOLUTION_COUNTS);

  logic [3:0]               stage_q;
  logic                     dec_q, inc_q;
  logic [12:0]              enc_q;
  logic signed [7:0]        step_q;
  logic signed [7:0]        rev_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [mft_pkg::POS_W-1:0] pos_q;

  logic signed [13:0] diff;
  logic signed [13:0] half_s;
  logic [6:0]         full_eff;
  logic signed [7:0]  full_pos, full_neg, wrap_val;
  logic signed [PROD_W-1:0] rev_ext;
  logic signed [PROD_W-1:0] pos_full;

  always_comb begin
    diff     = $signed({1'b0, encoder_now_i}) - $signed({1'b0, encoder_before_i});
    half_s   = $signed({1'b0, cfg_i.half_revolution});
    full_eff = (cfg_i.full_turn_count == '0) ? 7'd1 : cfg_i.full_turn_count;
    full_pos = $signed({1'b0, full_eff});
    full_neg = -full_pos;
    // reaching +F folds to -(F-1), reaching -F folds to F-1
    if (step_q == full_pos) begin
      wrap_val = full_neg + 8'sd1;
    end else if (step_q == full_neg) begin
      wrap_val = full_pos - 8'sd1;
    end else begin
      wrap_val = step_q;
    end
    rev_ext  = PROD_W'(rev_q);
    pos_full = prod_q + $signed(PROD_W'({1'b0, enc_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      rev_q   <= '0;
    end else begin
      stage_q <= {stage_q[2:0], start_i};
      if (stage_q[1]) begin
        rev_q <= wrap_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dec_q <= diff > half_s;
      inc_q <= diff < -half_s;
      enc_q <= encoder_now_i;
    end
    if (stage_q[0]) begin
      step_q <= dec_q ? (rev_q - 8'sd1) : (inc_q ? (rev_q + 8'sd1) : rev_q);
    end
    if (stage_q[2]) begin
      prod_q <= rev_ext * REV_COUNTS_S;
    end
    if (stage_q[3]) begin
      pos_q <= pos_full[mft_pkg::POS_W-1:0];
    end
  end

  assign stat_o.turn_count      = rev_q;
  assign stat_o.position_counts = pos_q;

endmodule

### hdl/mft_hold_timers.sv
// Saturating hold timers for both buttons and the switch-down condition.
// Depends on mft_pkg.
module mft_hold_timers (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                button_left_i,
  input  logic                button_right_i,
  input  logic                switch_down_i,
  input  logic                shooter_active_i,
  input  mft_pkg::cfg_t       cfg_i,
  output mft_pkg::hold_stat_t stat_o
);

  logic [15:0] left_q, right_q, switch_q;
  logic        left_last_q, right_last_q;
  logic        left_prev_q, right_prev_q;
  logic [15:0] left_d, right_d, switch_d;
  logic        switch_cond;

  always_comb begin
    switch_cond = switch_down_i && shooter_active_i;
    left_d   = !button_left_i ? '0 :
               ((left_q < cfg_i.press_hold_limit) ? left_q + 16'd1 : left_q);
    right_d  = !button_right_i ? '0 :
               ((right_q < cfg_i.press_hold_limit) ? right_q + 16'd1 : right_q);
    switch_d = !switch_cond ? '0 :
               ((switch_q < cfg_i.switch_hold_limit) ? switch_q + 16'd1 : switch_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      right_q      <= '0;
      switch_q     <= '0;
      left_last_q  <= 1'b0;
      right_last_q <= 1'b0;
      left_prev_q  <= 1'b0;
      right_prev_q <= 1'b0;
    end else if (start_i) begin
      left_q       <= left_d;
      right_q      <= right_d;
      switch_q     <= switch_d;
      left_prev_q  <= left_last_q;
      right_prev_q <= right_last_q;
      left_last_q  <= button_left_i;
      right_last_q <= button_right_i;
    end
  end

  assign stat_o.left_hold_time   = left_q;
  assign stat_o.right_hold_time  = right_q;
  assign stat_o.switch_hold_time = switch_q;
  assign stat_o.left_previous    = left_prev_q;
  assign stat_o.right_previous   = right_prev_q;

endmodule

### hdl/motor_feedback_tracker.sv
// Motor feedback tracker top level: config registers, sequencer, output register.
// Depends on mft_pkg, mft_if, mft_serial_mac, mft_turn_track, mft_hold_timers.
//
// Usage:
//   item_i   : one request per control tick (speed, encoder pair, buttons).
//   result_o : one request back per accepted sample, in order.
//   cfg_i    : register writes, index 0..4, always ready; unknown indexes are
//              dropped. Write only while no sample is in flight.
// Filter: one bit-serial MAC walks 17 multiplier bits for each of four products
//   (speed scaling, input, newer and older tap); the finish state then rounds
//   and saturates the result.
// Input: one sample at a time; item_i.ready is high only while the sequencer
//   is idle.
// Stall: a finished result sits in the output register until taken; the next
//   sample is still accepted meanwhile and parks in the last state until the
//   register frees.
// Reset: asynchronous, active low. Filter taps, turn counter, timers and
//   previous-button bits clear to zero; registers return to their defaults.
module motor_feedback_tracker #(
  parameter int REVOLUTION_COUNTS = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mft_item_if.sink           item_i,
  mft_result_if.source       result_o,
  mft_cfg_if.sink            cfg_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_INPUT,
    S_NEWER,
    S_OLDER,
    S_FINISH
  } state_e;

  state_e state_q;

  // ---- configuration registers ----
  mft_pkg::cfg_t cfg_q;
  logic          cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_scale       <= 16'd191;
      cfg_q.half_revolution   <= 13'd4096;
      cfg_q.full_turn_count   <= 7'd18;
      cfg_q.press_hold_limit  <= 16'd400;
      cfg_q.switch_hold_limit <= 16'd2000;
    end else if (cfg_fire) begin
      case (mft_pkg::cfg_reg_e'(cfg_i.index))
        mft_pkg::REG_SPEED_SCALE:       cfg_q.speed_scale       <= cfg_i.data;
        mft_pkg::REG_HALF_REVOLUTION:   cfg_q.half_revolution   <= cfg_i.data[12:0];
        mft_pkg::REG_FULL_TURN_COUNT:   cfg_q.full_turn_count   <= cfg_i.data[6:0];
        mft_pkg::REG_PRESS_HOLD_LIMIT:  cfg_q.press_hold_limit  <= cfg_i.data;
        mft_pkg::REG_SWITCH_HOLD_LIMIT: cfg_q.switch_hold_limit <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---- serial MAC status, needed by the input handshake ----
  mft_pkg::mac_ctrl_t                 mac_ctrl;
  mft_pkg::mac_stat_t                 mac_stat;

  // ---- handshakes ----
  logic in_fire;
  logic out_free;
  logic out_valid_q;
  logic load_out;
  mft_pkg::result_t out_q;

  assign item_i.ready   = (state_q == S_IDLE) && !mac_stat.busy;
  assign in_fire        = item_i.valid && item_i.ready;
  assign out_free       = !out_valid_q || result_o.ready;
  assign load_out       = (state_q == S_FINISH) && out_free;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // ---- serial MAC ----
  logic signed [mft_pkg::SPEED_W-1:0] mac_operand;
  logic        [mft_pkg::MULT_W-1:0]  mac_mult;
  logic signed [mft_pkg::ACC_W-1:0]   mac_init;
  logic signed [mft_pkg::ACC_W-1:0]   mac_acc;

  logic signed [mft_pkg::SPEED_W-1:0] newer_q, older_q;

  // Term order: rpm*scale first (exact, fits 32 bits), then the rounded
  // recursion c2*scaled + c0*newer - |c1|*older on a half-LSB seed.
  always_comb begin
    mac_ctrl    = '0;
    mac_operand = '0;
    mac_mult    = '0;
    mac_init    = '0;
    case (state_q)
      S_IDLE: begin
        mac_ctrl.start = in_fire;
        mac_ctrl.clear = 1'b1;
        mac_operand    = mft_pkg::SPEED_W'($signed(item_i.data.motor_rpm));
        mac_mult       = mft_pkg::MULT_W'(cfg_q.speed_scale);
      end
      S_SCALE: begin
        mac_ctrl.start = mac_stat.done;
        mac_ctrl.clear = 1'b1;
        mac_init       = mft_pkg::ROUND_HALF;
        mac_operand    = mac_acc[mft_pkg::SPEED_W-1:0];
        mac_mult       = mft_pkg::COEF_INPUT_MAG;
      end
      S_INPUT: begin
        mac_ctrl.start = mac_stat.done;
        mac_operand    = newer_q;
        mac_mult       = mft_pkg::COEF_NEWER_MAG;
      end
      S_NEWER: begin
        mac_ctrl.start  = mac_stat.done;
        mac_ctrl.negate = 1'b1;
        mac_operand     = older_q;
        mac_mult        = mft_pkg::COEF_OLDER_MAG;
      end
      default: ;
    endcase
  end

  mft_serial_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .operand_i (mac_operand),
    .mult_i    (mac_mult),
    .init_i    (mac_init),
    .stat_o    (mac_stat),
    .acc_o     (mac_acc)
  );

  // ---- side units, started at acceptance ----
  mft_pkg::turn_stat_t turn_stat;
  mft_pkg::hold_stat_t hold_stat;

  mft_turn_track #(
    .REVOLUTION_COUNTS (REVOLUTION_COUNTS)
  ) u_turn (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (in_fire),
    .encoder_now_i    (item_i.data.encoder_now),
    .encoder_before_i (item_i.data.encoder_before),
    .cfg_i            (cfg_q),
    .stat_o           (turn_stat)
  );

  mft_hold_timers u_hold (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (in_fire),
    .button_left_i    (item_i.data.button_left),
    .button_right_i   (item_i.data.button_right),
    .switch_down_i    (item_i.data.switch_down),
    .shooter_active_i (item_i.data.shooter_active),
    .cfg_i            (cfg_q),
    .stat_o           (hold_stat)
  );

  // ---- round (already seeded) and saturate to 32 bits ----
  localparam int TOP_LSB = mft_pkg::FRAC_W + mft_pkg::SPEED_W - 1;

  logic [mft_pkg::ACC_W-1-TOP_LSB:0]  acc_top;
  logic                               fits;
  logic signed [mft_pkg::SPEED_W-1:0] speed_new;

  always_comb begin
    acc_top = mac_acc[mft_pkg::ACC_W-1:TOP_LSB];
    fits    = (&acc_top) || !(|acc_top);
    if (fits) begin
      speed_new = mac_acc[TOP_LSB:mft_pkg::FRAC_W];
    end else if (mac_acc[mft_pkg::ACC_W-1]) begin
      speed_new = {1'b1, {(mft_pkg::SPEED_W-1){1'b0}}};
    end else begin
      speed_new = {1'b0, {(mft_pkg::SPEED_W-1){1'b1}}};
    end
  end

  // ---- sequencer, filter taps, output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      newer_q     <= '0;
      older_q     <= '0;
    end else begin
      // a loaded result stays valid until the receiver takes it
      out_valid_q <= load_out || (out_valid_q && !result_o.ready);
      case (state_q)
        S_IDLE:  if (in_fire)       state_q <= S_SCALE;
        S_SCALE: if (mac_stat.done) state_q <= S_INPUT;
        S_INPUT: if (mac_stat.done) state_q <= S_NEWER;
        S_NEWER: if (mac_stat.done) state_q <= S_OLDER;
        S_OLDER: if (mac_stat.done) state_q <= S_FINISH;
        S_FINISH: begin
          if (load_out) begin
            older_q     <= newer_q;
            newer_q     <= speed_new;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.filtered_speed   <= speed_new;
      out_q.turn_count       <= turn_stat.turn_count;
      out_q.position_counts  <= turn_stat.position_counts;
      out_q.left_hold_time   <= hold_stat.left_hold_time;
      out_q.right_hold_time  <= hold_stat.right_hold_time;
      out_q.switch_hold_time <= hold_stat.switch_hold_time;
      out_q.left_previous    <= hold_stat.left_previous;
      out_q.right_previous   <= hold_stat.right_previous;
    end
  end

endmodule

### hdl/mft_checker.sv
// Port-level checker for the motor feedback tracker, bound to the top level.
// Depends on mft_pkg and motor_feedback_tracker_defines.svh.
`include "motor_feedback_tracker_defines.svh"

module mft_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input mft_pkg::result_t out_data_i
);

  logic       in_fire, out_fire;
  logic [1:0] pending_q, pending_d;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // requests taken minus results delivered
  always_comb begin
    pending_d = pending_q;
    if (in_fire && !out_fire) begin
      pending_d = pending_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `MFT_ASSERT_NEXT(a_result_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "result changed while stalled")
  `MFT_ASSERT_NEXT(a_busy_after_take, in_fire, !in_ready_i, "sample taken while previous one in flight")
  `MFT_ASSERT_IMPL(a_no_extra_result, out_fire, pending_q != 2'd0, "result without a pending sample")
  `MFT_ASSERT_RST(a_reset_quiet, !rst_ni, !out_valid_i, "result valid during reset")

endmodule

bind motor_feedback_tracker mft_checker u_mft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);
